FILE: rtl/core/skf_pkg.sv
// skf_pkg: shared constants and the controller-to-datapath command type
// for the scalar kalman filter. no dependencies.
package skf_pkg;

   localparam int unsigned FRAC_BITS = 24;
   localparam int unsigned GAIN_W    = FRAC_BITS + 1;
   localparam int unsigned DIV_STEPS = GAIN_W;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   localparam logic [GAIN_W-1:0] ONE_Q24 = GAIN_W'(1) << FRAC_BITS;

   localparam logic [31:0] RESET_PROCESS_NOISE     = 32'd33554;
   localparam logic [31:0] RESET_MEASUREMENT_NOISE = 32'd838861;
   localparam logic [31:0] RESET_VARIANCE          = 32'd16777216;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASUREMENT_NOISE = 2'd1;

   typedef struct packed {
      logic load;       // capture measurement, form predicted variance
      logic prep;       // denominator, difference, divider init
      logic div_step;   // one restoring division step
      logic div_first;  // first step shifts in the low bit of p1
      logic mul1;       // gain fixup, low partial product, variance product
      logic mul2;       // high partial product
      logic sum;        // combine partial products into correction
      logic update;     // commit state and load result register
   } skf_cmd_type;

endpackage

FILE: rtl/core/skf_ctrl.sv
// skf_ctrl: sequencing state machine for the scalar kalman filter.
// depends on skf_pkg; drives skf_datapath through skf_cmd_type.
module skf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output skf_pkg::skf_cmd_type cmd
);
   import skf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_DIV,
      S_MUL1,
      S_MUL2,
      S_SUM,
      S_UPD
   } state_type;

   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIV_STEPS - 1);

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.prep      = (state_ff == S_PREP);
      cmd.div_step  = (state_ff == S_DIV);
      cmd.div_first = (state_ff == S_DIV) && (cnt_ff == LAST_CNT);
      cmd.mul1      = (state_ff == S_MUL1);
      cmd.mul2      = (state_ff == S_MUL2);
      cmd.sum       = (state_ff == S_SUM);
      cmd.update    = (state_ff == S_UPD) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_PREP;
            end
            S_PREP: begin
               cnt_ff   <= LAST_CNT;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) state_ff <= S_MUL1;
            end
            S_MUL1: state_ff <= S_MUL2;
            S_MUL2: state_ff <= S_SUM;
            S_SUM:  state_ff <= S_UPD;
            S_UPD: begin
               // hold until the result register is free
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/core/skf_datapath.sv
// skf_datapath: filter state, noise registers, serial divider, multipliers
// and result register. depends on skf_pkg; sequenced by skf_ctrl.
module skf_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  skf_pkg::skf_cmd_type               cmd,
   input  logic                               csr_write,
   input  logic [skf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                        csr_wdata,
   input  logic signed [31:0]                 req_measurement,
   output logic signed [31:0]                 rsp_estimate_out,
   output logic [skf_pkg::GAIN_W-1:0]         rsp_gain_out,
   output logic [31:0]                        rsp_variance_out
);
   import skf_pkg::*;

   localparam int unsigned LO_W   = 16;
   localparam int unsigned HI_W   = 33 - LO_W;
   localparam int unsigned PLO_W  = GAIN_W + LO_W;
   localparam int unsigned PHI_W  = GAIN_W + 1 + HI_W;
   localparam int unsigned SUM_W  = 32 + FRAC_BITS;
   localparam int unsigned PV_W   = 32 + GAIN_W;

   logic [31:0]              pn_ff;
   logic [31:0]              mn_ff;
   logic [31:0]              est_ff;
   logic [31:0]              var_ff;
   logic [31:0]              meas_ff;
   logic [31:0]              p1_ff;
   logic [32:0]              den_ff;
   logic [32:0]              diff_ff;
   logic [32:0]              rem_ff;
   logic [GAIN_W-1:0]        quot_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic [PLO_W-1:0]         prod_lo_ff;
   logic signed [PHI_W-1:0]  prod_hi_ff;
   logic [PV_W-1:0]          pv_ff;
   logic [31:0]              corr_ff;
   logic signed [31:0]       rsp_est_ff;
   logic [GAIN_W-1:0]        rsp_gain_ff;
   logic [31:0]              rsp_var_ff;

   logic [32:0]              p1_sum;
   logic [31:0]              p1_in;
   logic [33:0]              rem_shift;
   logic                     rem_ge;
   logic [32:0]              rem_in;
   logic [GAIN_W-1:0]        gain_in;
   logic [SUM_W-1:0]         total;
   logic [31:0]              est_in;
   logic [31:0]              var_in;

   // predicted variance, saturating
   assign p1_sum = {1'b0, var_ff} + {1'b0, pn_ff};
   assign p1_in  = p1_sum[32] ? 32'hFFFF_FFFF : p1_sum[31:0];

   // restoring division of p1 * 2^24 by den, quotient bit 24 first
   assign rem_shift = {rem_ff, cmd.div_first ? p1_ff[0] : 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, den_ff});
   assign rem_in    = rem_ge ? 33'(rem_shift - {1'b0, den_ff}) : rem_shift[32:0];

   assign gain_in = (den_ff == '0) ? '0 : quot_ff;

   // only the low bits feeding the truncated correction are needed
   assign total  = SUM_W'({prod_hi_ff, {LO_W{1'b0}}}) + SUM_W'(prod_lo_ff);
   assign est_in = est_ff + corr_ff;
   assign var_in = pv_ff[FRAC_BITS +: 32];

   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff  <= RESET_PROCESS_NOISE;
         mn_ff  <= RESET_MEASUREMENT_NOISE;
         est_ff <= '0;
         var_ff <= RESET_VARIANCE;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_PROCESS_NOISE: begin
                  pn_ff <= csr_wdata;
               end
               CSR_MEASUREMENT_NOISE: begin
                  mn_ff <= csr_wdata;
               end
               default: ;
            endcase
         end
         if (cmd.update) begin
            est_ff <= est_in;
            var_ff <= var_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         meas_ff <= req_measurement;
         p1_ff   <= p1_in;
      end
      if (cmd.prep) begin
         den_ff  <= {1'b0, p1_ff} + {1'b0, mn_ff};
         diff_ff <= {meas_ff[31], meas_ff} - {est_ff[31], est_ff};
         rem_ff  <= {2'b00, p1_ff[31:1]};
         quot_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[GAIN_W-2:0], rem_ge};
      end
      if (cmd.mul1) begin
         gain_ff    <= gain_in;
         prod_lo_ff <= PLO_W'(gain_in) * PLO_W'(diff_ff[LO_W-1:0]);
         pv_ff      <= PV_W'(p1_ff) * PV_W'(ONE_Q24 - gain_in);
      end
      if (cmd.mul2) begin
         prod_hi_ff <= PHI_W'($signed({1'b0, gain_ff})) * PHI_W'($signed(diff_ff[32:LO_W]));
      end
      if (cmd.sum) begin
         corr_ff <= total[FRAC_BITS +: 32];
      end
      if (cmd.update) begin
         rsp_est_ff  <= est_in;
         rsp_gain_ff <= gain_ff;
         rsp_var_ff  <= var_in;
      end
   end

   assign rsp_estimate_out = rsp_est_ff;
   assign rsp_gain_out     = rsp_gain_ff;
   assign rsp_variance_out = rsp_var_ff;

endmodule

FILE: rtl/core/scalar_kalman_filter.sv
// scalar_kalman_filter: top level, one measurement in, one result out.
// one request in flight at a time: req_ready is high only while idle, and
// the update waits for the result register to be free. the gain is formed by
// the 25-step restoring divider, one quotient bit per cycle.
// reset: synchronous, estimate 0, variance 1.0, noise registers defaults.
// depends on skf_pkg, skf_ctrl, skf_datapath.
module scalar_kalman_filter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [31:0]                 req_measurement,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_estimate_out,
   output logic [skf_pkg::GAIN_W-1:0]         rsp_gain_out,
   output logic [31:0]                        rsp_variance_out,
   input  logic                               csr_write,
   input  logic [skf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                        csr_wdata
);
   import skf_pkg::*;

   skf_cmd_type cmd;

   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   skf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_measurement  (req_measurement),
      .rsp_estimate_out (rsp_estimate_out),
      .rsp_gain_out     (rsp_gain_out),
      .rsp_variance_out (rsp_variance_out)
   );

`ifndef SYNTH
   // gain never exceeds 1.0
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gain_out <= ONE_Q24))
      else $error("gain above 1.0");

   // unity gain collapses the variance
   a_unity_gain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_gain_out == ONE_Q24)) |-> (rsp_variance_out == '0))
      else $error("variance nonzero at unity gain");

   // one transaction in flight at a time
   a_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");
`endif

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking testbench for scalar_kalman_filter, with its own
// fixed-point predictor, random idling on both channels and a watchdog.
// depends on skf_pkg and the scalar_kalman_filter rtl.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import skf_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;

   // indexes the block decodes to nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic signed [31:0] estimate;
      logic [GAIN_W-1:0]  gain;
      logic [31:0]        variance;
   } kalman_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [31:0]       req_measurement = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [31:0]       rsp_estimate_out;
   logic [GAIN_W-1:0]        rsp_gain_out;
   logic [31:0]              rsp_variance_out;
   logic                     csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [31:0]              csr_wdata = '0;

   // predictor state and its copy of the noise registers
   logic signed [31:0] model_estimate = '0;
   logic [31:0]        model_variance = RESET_VARIANCE;
   logic [31:0]        model_q        = RESET_PROCESS_NOISE;
   logic [31:0]        model_r        = RESET_MEASUREMENT_NOISE;

   kalman_result_type predicted_updates[$];

   int  error_count     = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  settings_used   = 0;
   int  idle_cycles     = 0;
   bit  sender_idling   = 1'b1;
   bit  rsp_stalls      = 1'b1;
   bit  hold_request    = 1'b0;

   scalar_kalman_filter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_measurement  (req_measurement),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_estimate_out (rsp_estimate_out),
      .rsp_gain_out     (rsp_gain_out),
      .rsp_variance_out (rsp_variance_out),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // one filter step: predict, gain, correct, shrink the variance
   function automatic kalman_result_type kalman_update(
      input logic signed [31:0] est,
      input logic [31:0]        prior_var,
      input logic [31:0]        q_noise,
      input logic [31:0]        r_noise,
      input logic signed [31:0] meas
   );
      logic [32:0]       prior_sum;
      logic [31:0]       p1;
      logic [63:0]       den;
      logic [63:0]       gain;
      logic [63:0]       scaled;
      longint            diff;
      longint            corr;
      kalman_result_type r;
      prior_sum = {1'b0, prior_var} + {1'b0, q_noise};
      p1 = prior_sum[32] ? 32'hFFFF_FFFF : prior_sum[31:0];
      den = 64'(p1) + 64'(r_noise);
      gain = (den == 64'd0) ? 64'd0 : ({32'd0, p1} << FRAC_BITS) / den;
      diff = longint'(meas) - longint'(est);
      corr = (longint'(gain) * diff) >>> FRAC_BITS;
      r.estimate = est + corr[31:0];
      r.gain = gain[GAIN_W-1:0];
      scaled = (64'(p1) * (64'(ONE_Q24) - gain)) >> FRAC_BITS;
      r.variance = scaled[31:0];
      return r;
   endfunction

   // predict on each accepted measurement, check each accepted result
   always @(posedge clock) begin
      kalman_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = kalman_update(model_estimate, model_variance, model_q, model_r,
                                 req_measurement);
            model_estimate = want.estimate;
            model_variance = want.variance;
            predicted_updates.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (predicted_updates.size() == 0) begin
               $error("result transaction with no prediction pending");
               error_count++;
            end else begin
               want = predicted_updates.pop_front();
               if (rsp_estimate_out !== want.estimate) begin
                  $error("estimate_out: expected %0d, got %0d", want.estimate,
                         rsp_estimate_out);
                  error_count++;
               end
               if (rsp_gain_out !== want.gain) begin
                  $error("gain_out: expected 0x%0h, got 0x%0h", want.gain, rsp_gain_out);
                  error_count++;
               end
               if (rsp_variance_out !== want.variance) begin
                  $error("variance_out: expected 0x%0h, got 0x%0h", want.variance,
                         rsp_variance_out);
                  error_count++;
               end
            end
         end
      end
   end

   // stop the run if no transaction moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // valid stays high after acceptance; the next call reuses it or lowers it for
   // a random idle gap, or the caller lowers it through wait_for_results
   task automatic send_measurement(input logic signed [31:0] meas);
      int gap;
      gap = 0;
      if (sender_idling && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_measurement <= meas;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_updates.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      unique case (idx)
         CSR_PROCESS_NOISE:     model_q = data;
         CSR_MEASUREMENT_NOISE: model_r = data;
         default: ;
      endcase
   endtask

   task automatic set_noise(input logic [31:0] q_noise, input logic [31:0] r_noise);
      wait_for_results();
      write_reg(CSR_PROCESS_NOISE, q_noise);
      write_reg(CSR_MEASUREMENT_NOISE, r_noise);
      settings_used++;
   endtask

   function automatic logic [31:0] pick_noise();
      unique case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom;
         3:       return $urandom_range(0, 1 << 20);
         4:       return $urandom_range(1 << 20, 1 << 26);
         default: return RESET_MEASUREMENT_NOISE;
      endcase
   endfunction

   // mostly a noisy constant level, sometimes anything, sometimes a rail
   function automatic logic signed [31:0] next_measurement(input logic signed [31:0] level);
      int unsigned pick;
      int          spread;
      int          noise;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         spread = $urandom_range(1, 1 << 20);
         noise = int'($urandom_range(0, 2 * spread)) - spread;
         return level + noise;
      end
      if (pick < 17)
         return $urandom;
      unique case ($urandom_range(0, 3))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 32'sh0000_0000;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic logic signed [31:0] random_level();
      return $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
   endfunction

   task automatic test_reset_defaults();
      send_measurement(32'sh0000_0000);
      send_measurement(32'sh0001_0000);
      send_measurement(-32'sh0001_0000);
      send_measurement(32'sh7FFF_FFFF);
      send_measurement(32'sh8000_0000);
   endtask

   // gain of exactly one: estimate jumps rail to rail
   task automatic test_zero_measurement_noise();
      set_noise(RESET_PROCESS_NOISE, 32'd0);
      send_measurement(32'sh7FFF_FFFF);
      send_measurement(32'sh8000_0000);
      send_measurement(32'sh0000_0000);
   endtask

   // the variance left at zero by the previous test and zero noise make the denominator zero
   task automatic test_zero_denominator();
      set_noise(32'd0, 32'd0);
      send_measurement(32'sh0123_4567);
      send_measurement(32'sh0000_3039);
      send_measurement(32'sh8000_0000);
      send_measurement(32'sh7FFF_FFFF);
   endtask

   task automatic test_variance_saturation();
      set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_measurement(32'sh7FFF_FFFF);
      send_measurement(32'sh8000_0000);
      send_measurement(-32'sd1);
      send_measurement(32'sh0000_0001);
      set_noise(32'hFFFF_FFFF, 32'd0);
      send_measurement(32'sh8000_0000);
      send_measurement(32'sh7FFF_FFFF);
   endtask

   task automatic test_unused_register_index();
      set_noise(RESET_PROCESS_NOISE, RESET_MEASUREMENT_NOISE);
      write_reg(CSR_SPARE_2, $urandom);
      write_reg(CSR_SPARE_3, $urandom);
      send_measurement(32'sh0010_0000);
      send_measurement(-32'sh0010_0000);
      send_measurement(32'sh0000_8000);
   endtask

   // hold the result side while the sender keeps offering
   task automatic test_backpressure();
      logic signed [31:0] level;
      level = random_level();
      wait_for_results();
      sender_idling = 1'b0;
      hold_request = 1'b1;
      repeat (10) send_measurement(next_measurement(level));
      sender_idling = 1'b1;
   endtask

   task automatic test_random_tracking(input int phases, input int per_phase);
      logic signed [31:0] level;
      int                 p;
      int                 i;
      for (p = 0; p < phases; p++) begin
         set_noise(pick_noise(), pick_noise());
         sender_idling = ($urandom_range(0, 2) != 0);
         rsp_stalls = ($urandom_range(0, 2) != 0);
         level = random_level();
         for (i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 29) == 0)
               level = random_level();
            send_measurement(next_measurement(level));
         end
      end
   endtask

   // back to back with no idling anywhere
   task automatic test_steady_stream(input int count);
      logic signed [31:0] level;
      set_noise(RESET_PROCESS_NOISE, RESET_MEASUREMENT_NOISE);
      sender_idling = 1'b0;
      rsp_stalls = 1'b0;
      level = random_level();
      repeat (count) send_measurement(next_measurement(level));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_measurement_noise();
      test_zero_denominator();
      test_variance_saturation();
      test_unused_register_index();
      test_backpressure();
      test_random_tracking(7, 45);
      test_steady_stream(60);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_updates.size() != 0) begin
         $error("%0d predicted results never arrived", predicted_updates.size());
         error_count++;
      end
      $display("sent %0d measurements, checked %0d results over %0d noise settings",
               items_sent, results_checked, settings_used);
      $display("included rail inputs, zero noise, zero denominator, saturation, spare writes");
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
